// File: hdl/stht_pkg.sv
// Shared types and constants for the segment/triangle hit test.
`timescale 1ns / 1ps

package stht_pkg;

    // Point slots: segment start, segment end, then the three vertices
    localparam int NUM_PTS   = 5;
    localparam int NUM_EDGES = 3;
    localparam int NUM_CROSS = 9;

    typedef logic [2:0] t_pt_idx;

    localparam t_pt_idx PT_S  = 3'd0;
    localparam t_pt_idx PT_E  = 3'd1;
    localparam t_pt_idx PT_V0 = 3'd2;
    localparam t_pt_idx PT_V1 = 3'd3;
    localparam t_pt_idx PT_V2 = 3'd4;

    // First slot of each group of three cross products in the table
    localparam int X_SEG_VERT  = 0;   // orient(S, E, Vj)
    localparam int X_EDGE_S    = 3;   // orient(Vi, Vi+1, S)
    localparam int X_EDGE_E    = 6;   // orient(Vi, Vi+1, E)

    // Turn p -> q -> r, sign of (q - p) x (r - q)
    typedef struct packed {
        t_pt_idx p;
        t_pt_idx q;
        t_pt_idx r;
    } t_tri;

    localparam t_tri CROSS_PTS [NUM_CROSS] = '{
        '{PT_S,  PT_E,  PT_V0},
        '{PT_S,  PT_E,  PT_V1},
        '{PT_S,  PT_E,  PT_V2},
        '{PT_V0, PT_V1, PT_S },
        '{PT_V1, PT_V2, PT_S },
        '{PT_V2, PT_V0, PT_S },
        '{PT_V0, PT_V1, PT_E },
        '{PT_V1, PT_V2, PT_E },
        '{PT_V2, PT_V0, PT_E }
    };

    // Sign of a cross product; zero always has neg clear, so == compares signs
    typedef struct packed {
        logic neg;
        logic zro;
    } t_sgn;

endpackage

// File: hdl/stht_cross.sv
// Coordinate differences and the two partial products of each orientation term.
`timescale 1ns / 1ps

module stht_cross #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0]     i_px     [stht_pkg::NUM_PTS],
    input  logic signed [COORD_BITS-1:0]     i_py     [stht_pkg::NUM_PTS],
    output logic signed [2*COORD_BITS+1:0]   o_prod_a [stht_pkg::NUM_CROSS],
    output logic signed [2*COORD_BITS+1:0]   o_prod_b [stht_pkg::NUM_CROSS]
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;

    // One orientation term per table row: (q-p).x*(r-q).y and (q-p).y*(r-q).x
    for (genvar k = 0; k < stht_pkg::NUM_CROSS; k++) begin : g_cross
        logic signed [DW-1:0] w_dx_pq;
        logic signed [DW-1:0] w_dy_pq;
        logic signed [DW-1:0] w_dx_qr;
        logic signed [DW-1:0] w_dy_qr;

        assign w_dx_pq = DW'(i_px[stht_pkg::CROSS_PTS[k].q]) -
                         DW'(i_px[stht_pkg::CROSS_PTS[k].p]);
        assign w_dy_pq = DW'(i_py[stht_pkg::CROSS_PTS[k].q]) -
                         DW'(i_py[stht_pkg::CROSS_PTS[k].p]);
        assign w_dx_qr = DW'(i_px[stht_pkg::CROSS_PTS[k].r]) -
                         DW'(i_px[stht_pkg::CROSS_PTS[k].q]);
        assign w_dy_qr = DW'(i_py[stht_pkg::CROSS_PTS[k].r]) -
                         DW'(i_py[stht_pkg::CROSS_PTS[k].q]);

        assign o_prod_a[k] = PW'(w_dx_pq) * PW'(w_dy_qr);
        assign o_prod_b[k] = PW'(w_dy_pq) * PW'(w_dx_qr);
    end

endmodule

// File: hdl/stht_decide.sv
// Orientation signs, edge crossing / touch tests and the strict-inside test.
`timescale 1ns / 1ps

module stht_decide #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0]     i_px     [stht_pkg::NUM_PTS],
    input  logic signed [COORD_BITS-1:0]     i_py     [stht_pkg::NUM_PTS],
    input  logic signed [2*COORD_BITS+1:0]   i_prod_a [stht_pkg::NUM_CROSS],
    input  logic signed [2*COORD_BITS+1:0]   i_prod_b [stht_pkg::NUM_CROSS],
    output logic                             o_hit
);

    localparam int PW = 2 * COORD_BITS + 2;
    localparam int SW = PW + 1;

    stht_pkg::t_sgn                   w_sgn      [stht_pkg::NUM_CROSS];
    logic [stht_pkg::NUM_EDGES-1:0]   w_edge_hit;
    logic                             w_inside;

    // m lies within [min(a,b), max(a,b)] on one axis
    function automatic logic between(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b,
        input logic signed [COORD_BITS-1:0] m
    );
        return (m <= a || m <= b) && (m >= a || m >= b);
    endfunction

    // Exact sign of each cross product
    for (genvar k = 0; k < stht_pkg::NUM_CROSS; k++) begin : g_sign
        logic signed [SW-1:0] w_diff;

        assign w_diff       = SW'(i_prod_a[k]) - SW'(i_prod_b[k]);
        assign w_sgn[k].neg = w_diff[SW-1];
        assign w_sgn[k].zro = (w_diff == '0);
    end

    // Segment against each triangle edge Vi -> Vj
    for (genvar i = 0; i < stht_pkg::NUM_EDGES; i++) begin : g_edge
        localparam int J  = (i + 1) % stht_pkg::NUM_EDGES;
        localparam int VI = int'(stht_pkg::PT_V0) + i;
        localparam int VJ = int'(stht_pkg::PT_V0) + J;
        localparam int S  = int'(stht_pkg::PT_S);
        localparam int E  = int'(stht_pkg::PT_E);

        stht_pkg::t_sgn w_o1;
        stht_pkg::t_sgn w_o2;
        stht_pkg::t_sgn w_o3;
        stht_pkg::t_sgn w_o4;
        logic           w_cross;
        logic           w_touch;

        assign w_o1 = w_sgn[stht_pkg::X_SEG_VERT + i];
        assign w_o2 = w_sgn[stht_pkg::X_SEG_VERT + J];
        assign w_o3 = w_sgn[stht_pkg::X_EDGE_S + i];
        assign w_o4 = w_sgn[stht_pkg::X_EDGE_E + i];

        assign w_cross = (w_o1 != w_o2) && (w_o3 != w_o4);

        // Collinear endpoint inside the other segment's bounding box
        assign w_touch =
            (w_o1.zro && between(i_px[S], i_px[E], i_px[VI]) &&
                         between(i_py[S], i_py[E], i_py[VI])) ||
            (w_o2.zro && between(i_px[S], i_px[E], i_px[VJ]) &&
                         between(i_py[S], i_py[E], i_py[VJ])) ||
            (w_o3.zro && between(i_px[VI], i_px[VJ], i_px[S]) &&
                         between(i_py[VI], i_py[VJ], i_py[S])) ||
            (w_o4.zro && between(i_px[VI], i_px[VJ], i_px[E]) &&
                         between(i_py[VI], i_py[VJ], i_py[E]));

        assign w_edge_hit[i] = w_cross || w_touch;
    end

    // Start point strictly left of every triangle edge (counterclockwise triangle)
    always_comb begin
        w_inside = 1'b1;
        for (int i = 0; i < stht_pkg::NUM_EDGES; i++) begin
            w_inside = w_inside && !w_sgn[stht_pkg::X_EDGE_S + i].neg &&
                       !w_sgn[stht_pkg::X_EDGE_S + i].zro;
        end
    end

    assign o_hit = (|w_edge_hit) || w_inside;

endmodule

// File: hdl/segment_triangle_hit_test_top.sv
// Top level: three-register pipeline around the product and decision logic.
// Each transaction passes the input, product and result registers. Throughput:
// one transaction per cycle unless stalled; the 18 parallel multipliers of the
// product stage set the clock, each followed by its own register.
// Stalls back up through the stages; o_stall rises only when all three are full.
// Reset (i_rst_n low, synchronous) empties every stage; payloads are not reset.
`timescale 1ns / 1ps

module segment_triangle_hit_test_top #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_BITS-1:0]  i_seg_start_x,
    input  logic signed [COORD_BITS-1:0]  i_seg_start_y,
    input  logic signed [COORD_BITS-1:0]  i_seg_end_x,
    input  logic signed [COORD_BITS-1:0]  i_seg_end_y,
    input  logic signed [COORD_BITS-1:0]  i_vert0_x,
    input  logic signed [COORD_BITS-1:0]  i_vert0_y,
    input  logic signed [COORD_BITS-1:0]  i_vert1_x,
    input  logic signed [COORD_BITS-1:0]  i_vert1_y,
    input  logic signed [COORD_BITS-1:0]  i_vert2_x,
    input  logic signed [COORD_BITS-1:0]  i_vert2_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit
);

    localparam int PW = 2 * COORD_BITS + 2;

    logic signed [COORD_BITS-1:0] w_in_x [stht_pkg::NUM_PTS];
    logic signed [COORD_BITS-1:0] w_in_y [stht_pkg::NUM_PTS];

    // Stage 1: input register
    logic                         r_v1;
    logic signed [COORD_BITS-1:0] r_px1 [stht_pkg::NUM_PTS];
    logic signed [COORD_BITS-1:0] r_py1 [stht_pkg::NUM_PTS];

    // Stage 2: product register, coordinates carried for the box tests
    logic                         r_v2;
    logic signed [COORD_BITS-1:0] r_px2 [stht_pkg::NUM_PTS];
    logic signed [COORD_BITS-1:0] r_py2 [stht_pkg::NUM_PTS];
    logic signed [PW-1:0]         r_pa  [stht_pkg::NUM_CROSS];
    logic signed [PW-1:0]         r_pb  [stht_pkg::NUM_CROSS];

    // Stage 3: result register
    logic                         r_v3;
    logic                         r_hit;

    logic signed [PW-1:0]         w_pa [stht_pkg::NUM_CROSS];
    logic signed [PW-1:0]         w_pb [stht_pkg::NUM_CROSS];
    logic                         w_hit;
    logic                         w_ld1;
    logic                         w_ld2;
    logic                         w_ld3;

    // Gather the input transaction into point slots
    assign w_in_x[stht_pkg::PT_S]  = i_seg_start_x;
    assign w_in_y[stht_pkg::PT_S]  = i_seg_start_y;
    assign w_in_x[stht_pkg::PT_E]  = i_seg_end_x;
    assign w_in_y[stht_pkg::PT_E]  = i_seg_end_y;
    assign w_in_x[stht_pkg::PT_V0] = i_vert0_x;
    assign w_in_y[stht_pkg::PT_V0] = i_vert0_y;
    assign w_in_x[stht_pkg::PT_V1] = i_vert1_x;
    assign w_in_y[stht_pkg::PT_V1] = i_vert1_y;
    assign w_in_x[stht_pkg::PT_V2] = i_vert2_x;
    assign w_in_y[stht_pkg::PT_V2] = i_vert2_y;

    // A stage loads when it is empty or its contents move on
    assign w_ld3   = !r_v3 || !i_stall;
    assign w_ld2   = !r_v2 || w_ld3;
    assign w_ld1   = !r_v1 || w_ld2;
    assign o_stall = !w_ld1;

    stht_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .i_px     (r_px1),
        .i_py     (r_py1),
        .o_prod_a (w_pa),
        .o_prod_b (w_pb)
    );

    stht_decide #(
        .COORD_BITS (COORD_BITS)
    ) u_decide (
        .i_px     (r_px2),
        .i_py     (r_py2),
        .i_prod_a (r_pa),
        .i_prod_b (r_pb),
        .o_hit    (w_hit)
    );

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ld1) begin
                r_v1 <= i_valid;
            end
            if (w_ld2) begin
                r_v2 <= r_v1;
            end
            if (w_ld3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (w_ld1 && i_valid) begin
            r_px1 <= w_in_x;
            r_py1 <= w_in_y;
        end
        if (w_ld2 && r_v1) begin
            r_px2 <= r_px1;
            r_py2 <= r_py1;
            r_pa  <= w_pa;
            r_pb  <= w_pb;
        end
        if (w_ld3 && r_v2) begin
            r_hit <= w_hit;
        end
    end

    assign o_valid = r_v3;
    assign o_hit   = r_hit;

endmodule

// File: hdl/stht_checker.sv
// Port-level checks for the hit test top level, bound onto every instance.
`timescale 1ns / 1ps

module stht_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_hit
);

    // Reset empties the output stage
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("o_valid set after reset");

    // With a free output stage the pipeline always has room for a transaction
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("o_stall raised while the pipeline can advance");

    // A stalled result holds its value
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_hit)))
        else $error("stalled result changed or dropped");

    // A result leaves only when taken
    a_drop_only_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_valid) |-> $past(!i_stall))
        else $error("o_valid fell without a transaction");

endmodule

bind segment_triangle_hit_test_top stht_checker u_stht_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_hit   (o_hit)
);
